@@ rtl/ccps_pkg.sv @@
// ----------------------------------------------------------------------------
// ccps_pkg
// Shared types, sizes and helpers for the circle collision physics step.
// ----------------------------------------------------------------------------
package ccps_pkg;

	localparam int MAX_OBJECTS = 64;
	localparam int AW = $clog2(MAX_OBJECTS);
	localparam int CW = AW + 1;

	// configuration register indexes
	localparam logic [1:0] CFG_ITERATIONS = 2'd0;
	localparam logic [1:0] CFG_FRICTION   = 2'd1;

	localparam logic [7:0]  ITERATIONS_RESET = 8'd10;
	localparam logic [16:0] FRICTION_RESET   = 17'd65307;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic        [31:0] mass;
		logic        [30:0] radius;
		logic               last;
	} circle_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic               final_circle;
	} result_t;

	// one stored circle
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic        [31:0] mass;
		logic        [30:0] radius;
	} entry_t;

	// clamp a wide signed value to 32 bit signed
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/ccps_div.sv @@
// ----------------------------------------------------------------------------
// ccps_div
// Unsigned 64 by 64 bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccps_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic [63:0] quot,
	output logic        done
);
	import ccps_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] num_q;
	logic [63:0] den_q;
	logic [64:0] rem_q;
	logic [63:0] quot_q;

	logic [64:0] rem_sh;
	logic [65:0] diff;
	logic        ge;

	// trial subtract of the shifted remainder
	always_comb begin
		rem_sh = {rem_q[63:0], num_q[63]};
		diff   = {1'b0, rem_sh} - {2'b00, den_q};
		ge     = ~diff[65];
	end

	// advance one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				quot_q <= '0;
			end else if (busy_q) begin
				rem_q  <= ge ? diff[64:0] : rem_sh;
				quot_q <= {quot_q[62:0], ge};
				num_q  <= {num_q[62:0], 1'b0};
				cnt_q  <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

@@ rtl/ccps_sqrt.sv @@
// ----------------------------------------------------------------------------
// ccps_sqrt
// Integer square root of a 64 bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module ccps_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic [31:0] root,
	output logic        done
);
	import ccps_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [63:0] x_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = r_q + bit_q;

	// digit by digit root, two radicand bits a step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				x_q    <= x;
				r_q    <= '0;
				bit_q  <= 64'h4000_0000_0000_0000;
			end else if (busy_q) begin
				if (x_q >= trial) begin
					x_q <= x_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign root = r_q[31:0];
	assign done = done_q;

endmodule

@@ rtl/circle_collision_physics_step.sv @@
// ----------------------------------------------------------------------------
// circle_collision_physics_step
// Loads a frame of circles, resolves pairwise overlaps and impulses, then
// applies friction and motion and streams the circles back out.
// ----------------------------------------------------------------------------
// Circles are taken one per cycle into an on-chip store until one is marked
// last or the store holds MAX_OBJECTS; the input then stalls while the frame
// runs. Each collision pass visits every pair once in load order through one
// read-modify-write of the store, with a shared pipelined multiplier, an
// iterative square root and an iterative divider. A pair that does not touch
// ends early, as does one whose centres coincide; a touching pair takes the
// impulse steps only when it is approaching. A frame runs the configured
// number of passes over its N*(N-1)/2 pairs, then the final motion step and
// output handle one circle at a time, bounded also by how fast results are
// taken.
// ----------------------------------------------------------------------------
module circle_collision_physics_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              circle_valid,
	output logic              circle_stall,
	input  ccps_pkg::circle_t circle,
	output logic              result_valid,
	input  logic              result_stall,
	output ccps_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [16:0]       cfg_data
);
	import ccps_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE, S_READ, S_LOAD, S_ABS, S_HX, S_HY, S_HS, S_SQRT,
		S_DIVX, S_DIVY, S_DIVW, S_MX, S_MY, S_PAX, S_PAY, S_PBX, S_PBY,
		S_VREL, S_VNX, S_VNY, S_JIMP, S_J1, S_J2, S_VAX, S_VAY, S_VBX, S_VBY,
		S_WRA, S_WRB, S_NEXT, F_READ, F_LOAD, F_VX, F_VY, F_POS, F_EMIT
	} state_t;

	typedef enum logic [1:0] {SH0, SH16, SH30} shift_t;

	state_t state_q;

	// configuration
	logic [7:0]  iter_q;
	logic [16:0] fric_q;

	// frame bookkeeping
	logic [AW-1:0] count_q;
	logic [CW-1:0] n_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] k_q;
	logic [7:0]    it_q;
	logic          issued_q;

	// store
	entry_t        mem [MAX_OBJECTS];
	entry_t        rd_a_q;
	entry_t        rd_b_q;
	logic          rd_en;
	logic [AW-1:0] rd_addr_a;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;

	// pair working set
	entry_t             cur_i_q;
	entry_t             cur_j_q;
	logic signed [32:0] dx_q;
	logic signed [32:0] dy_q;
	logic        [31:0] adx_q;
	logic        [31:0] ady_q;
	logic        [32:0] rsum_q;
	logic        [32:0] msum_q;
	logic        [63:0] h_q;
	logic        [32:0] d_q;
	logic        [31:0] overlap_q;
	logic signed [31:0] nx_q;
	logic signed [31:0] ny_q;
	logic        [16:0] w_q;
	logic        [16:0] wc;
	logic signed [33:0] mx_q;
	logic signed [33:0] my_q;
	logic signed [32:0] vx_q;
	logic signed [32:0] vy_q;
	logic signed [34:0] vn_q;
	logic        [33:0] jimp_q;
	logic        [33:0] j1_q;
	logic        [33:0] j2_q;
	logic signed [36:0] nv2;

	// output register
	logic    res_valid_q;
	result_t res_q;

	// multiplier pipeline
	logic               mul_go;
	logic               is_mul;
	logic signed [35:0] ma_op;
	logic signed [32:0] mb_op;
	shift_t             msh_op;
	logic signed [35:0] ma_abs;
	logic signed [32:0] mb_abs;
	logic               v_s1, v_s2, v_s3;
	logic        [33:0] am_s1;
	logic        [31:0] bm_s1;
	logic               neg_s1, neg_s2;
	shift_t             sh_s1, sh_s2;
	logic        [65:0] prod_s2;
	logic        [65:0] prod_sh;
	logic signed [63:0] mres_s3;

	// divider and root
	logic        div_go;
	logic [63:0] div_num;
	logic [63:0] div_den;
	logic [63:0] div_quot;
	logic        div_done;
	logic [63:0] q_clamp;
	logic        sq_go;
	logic [31:0] sq_root;
	logic        sq_done;
	logic [32:0] d_new;

	logic          accept;
	logic          out_free;
	logic [CW-1:0] n_load;

	assign accept       = circle_valid && !circle_stall;
	assign circle_stall = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign out_free     = !res_valid_q || !result_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign wc           = 17'd65536 - w_q;
	assign n_load       = {1'b0, count_q} + CW'(1);
	assign d_new        = {sq_root, 1'b0};
	assign nv2          = -$signed({vn_q[34], vn_q, 1'b0});
	assign q_clamp      = (div_quot > 64'd1073741824) ? 64'd1073741824 : div_quot;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= ITERATIONS_RESET;
			fric_q <= FRICTION_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ITERATIONS: iter_q <= cfg_data[7:0];
				CFG_FRICTION:   fric_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// select store write port and read addresses
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q;
		wr_data = '{circle.pos_x, circle.pos_y, circle.vel_x, circle.vel_y,
			circle.mass, circle.radius};
		case (state_q)
			S_IDLE: wr_en = accept;
			S_WRA: begin
				wr_en   = 1'b1;
				wr_addr = i_q;
				wr_data = cur_i_q;
			end
			S_WRB: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = cur_j_q;
			end
			default: ;
		endcase
		rd_en     = (state_q == S_READ) || (state_q == F_READ);
		rd_addr_a = (state_q == F_READ) ? k_q : i_q;
	end

	// circle store, one write and two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[j_q];
		end
	end

	// select multiplier operands per step
	always_comb begin
		is_mul = 1'b1;
		ma_op  = '0;
		mb_op  = '0;
		msh_op = SH0;
		case (state_q)
			S_HX: begin
				ma_op = $signed({5'b0, adx_q[31:1]});
				mb_op = $signed({2'b0, adx_q[31:1]});
			end
			S_HY: begin
				ma_op = $signed({5'b0, ady_q[31:1]});
				mb_op = $signed({2'b0, ady_q[31:1]});
			end
			S_HS: begin
				ma_op = $signed({5'b0, rsum_q[31:1]});
				mb_op = $signed({2'b0, rsum_q[31:1]});
			end
			S_MX: begin
				ma_op  = $signed({4'b0, overlap_q});
				mb_op  = {nx_q[31], nx_q};
				msh_op = SH30;
			end
			S_MY: begin
				ma_op  = $signed({4'b0, overlap_q});
				mb_op  = {ny_q[31], ny_q};
				msh_op = SH30;
			end
			S_PAX: begin
				ma_op  = {{2{mx_q[33]}}, mx_q};
				mb_op  = $signed({16'b0, w_q});
				msh_op = SH16;
			end
			S_PAY: begin
				ma_op  = {{2{my_q[33]}}, my_q};
				mb_op  = $signed({16'b0, w_q});
				msh_op = SH16;
			end
			S_PBX: begin
				ma_op  = {{2{mx_q[33]}}, mx_q};
				mb_op  = $signed({16'b0, wc});
				msh_op = SH16;
			end
			S_PBY: begin
				ma_op  = {{2{my_q[33]}}, my_q};
				mb_op  = $signed({16'b0, wc});
				msh_op = SH16;
			end
			S_VNX: begin
				ma_op  = {{3{vx_q[32]}}, vx_q};
				mb_op  = {nx_q[31], nx_q};
				msh_op = SH30;
			end
			S_VNY: begin
				ma_op  = {{3{vy_q[32]}}, vy_q};
				mb_op  = {ny_q[31], ny_q};
				msh_op = SH30;
			end
			S_J1: begin
				ma_op  = $signed({2'b0, jimp_q});
				mb_op  = $signed({16'b0, w_q});
				msh_op = SH16;
			end
			S_J2: begin
				ma_op  = $signed({2'b0, jimp_q});
				mb_op  = $signed({16'b0, wc});
				msh_op = SH16;
			end
			S_VAX: begin
				ma_op  = $signed({2'b0, j1_q});
				mb_op  = {nx_q[31], nx_q};
				msh_op = SH30;
			end
			S_VAY: begin
				ma_op  = $signed({2'b0, j1_q});
				mb_op  = {ny_q[31], ny_q};
				msh_op = SH30;
			end
			S_VBX: begin
				ma_op  = $signed({2'b0, j2_q});
				mb_op  = {nx_q[31], nx_q};
				msh_op = SH30;
			end
			S_VBY: begin
				ma_op  = $signed({2'b0, j2_q});
				mb_op  = {ny_q[31], ny_q};
				msh_op = SH30;
			end
			F_VX: begin
				ma_op  = {{4{cur_i_q.vel_x[31]}}, cur_i_q.vel_x};
				mb_op  = $signed({16'b0, fric_q});
				msh_op = SH16;
			end
			F_VY: begin
				ma_op  = {{4{cur_i_q.vel_y[31]}}, cur_i_q.vel_y};
				mb_op  = $signed({16'b0, fric_q});
				msh_op = SH16;
			end
			default: is_mul = 1'b0;
		endcase
		mul_go = is_mul && !issued_q;
		ma_abs = ma_op[35] ? -ma_op : ma_op;
		mb_abs = mb_op[32] ? -mb_op : mb_op;
	end

	// select divider and root operands
	always_comb begin
		div_num = {2'b0, adx_q, 30'b0};
		div_den = {31'b0, d_q};
		div_go  = 1'b0;
		sq_go   = (state_q == S_SQRT) && !issued_q;
		case (state_q)
			S_DIVX: div_go = !issued_q;
			S_DIVY: begin
				div_num = {2'b0, ady_q, 30'b0};
				div_go  = !issued_q;
			end
			S_DIVW: begin
				div_num = {16'b0, cur_j_q.mass, 16'b0};
				div_den = {31'b0, msum_q};
				div_go  = !issued_q && (msum_q != '0);
			end
			default: ;
		endcase
	end

	// shift the registered product by the step's scale
	always_comb begin
		case (sh_s2)
			SH16:    prod_sh = prod_s2 >> 16;
			SH30:    prod_sh = prod_s2 >> 30;
			default: prod_sh = prod_s2;
		endcase
	end

	// multiplier: magnitudes, product, signed scaled result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= mul_go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		am_s1   <= ma_abs[33:0];
		bm_s1   <= mb_abs[31:0];
		neg_s1  <= ma_op[35] ^ mb_op[32];
		sh_s1   <= msh_op;
		prod_s2 <= {32'b0, am_s1} * {34'b0, bm_s1};
		neg_s2  <= neg_s1;
		sh_s2   <= sh_s1;
		mres_s3 <= neg_s2 ? -$signed(prod_sh[63:0]) : $signed(prod_sh[63:0]);
	end

	ccps_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_go),
		.x      (h_q),
		.root   (sq_root),
		.done   (sq_done)
	);

	ccps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.done   (div_done)
	);

	// sequence the load, the pair passes and the output sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			it_q        <= '0;
			issued_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// drop the result once transferred, unless the next one loads now
			if (res_valid_q && !result_stall && (state_q != F_EMIT)) begin
				res_valid_q <= 1'b0;
			end
			// mark a unit request as launched
			if ((mul_go || div_go || sq_go) && !issued_q) begin
				issued_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (circle.last || (count_q == AW'(MAX_OBJECTS - 1))) begin
							n_q     <= n_load;
							count_q <= '0;
							i_q     <= '0;
							j_q     <= AW'(1);
							k_q     <= '0;
							it_q    <= '0;
							if ((iter_q == '0) || (n_load < CW'(2))) begin
								state_q <= F_READ;
							end else begin
								state_q <= S_READ;
							end
						end else begin
							count_q <= count_q + AW'(1);
						end
					end
				end
				S_READ: state_q <= S_LOAD;
				S_LOAD: begin
					cur_i_q <= rd_a_q;
					cur_j_q <= rd_b_q;
					dx_q    <= {rd_a_q.pos_x[31], rd_a_q.pos_x}
						- {rd_b_q.pos_x[31], rd_b_q.pos_x};
					dy_q    <= {rd_a_q.pos_y[31], rd_a_q.pos_y}
						- {rd_b_q.pos_y[31], rd_b_q.pos_y};
					rsum_q  <= {2'b0, rd_a_q.radius} + {2'b0, rd_b_q.radius};
					msum_q  <= {1'b0, rd_a_q.mass} + {1'b0, rd_b_q.mass};
					state_q <= S_ABS;
				end
				S_ABS: begin
					adx_q <= dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
					ady_q <= dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
					if ((dx_q == '0) && (dy_q == '0)) begin
						state_q <= S_NEXT;
					end else begin
						state_q <= S_HX;
					end
				end
				S_HX: if (v_s3) begin
					h_q      <= $unsigned(mres_s3);
					issued_q <= 1'b0;
					state_q  <= S_HY;
				end
				S_HY: if (v_s3) begin
					h_q      <= h_q + $unsigned(mres_s3);
					issued_q <= 1'b0;
					state_q  <= S_HS;
				end
				S_HS: if (v_s3) begin
					issued_q <= 1'b0;
					state_q  <= (h_q > $unsigned(mres_s3)) ? S_NEXT : S_SQRT;
				end
				S_SQRT: if (sq_done) begin
					issued_q  <= 1'b0;
					d_q       <= d_new;
					overlap_q <= (rsum_q > d_new) ? 32'(rsum_q - d_new) : '0;
					state_q   <= (sq_root == '0) ? S_NEXT : S_DIVX;
				end
				S_DIVX: if (div_done) begin
					issued_q <= 1'b0;
					nx_q     <= dx_q[32] ? -$signed({1'b0, q_clamp[30:0]})
						: $signed({1'b0, q_clamp[30:0]});
					state_q  <= S_DIVY;
				end
				S_DIVY: if (div_done) begin
					issued_q <= 1'b0;
					ny_q     <= dy_q[32] ? -$signed({1'b0, q_clamp[30:0]})
						: $signed({1'b0, q_clamp[30:0]});
					state_q  <= S_DIVW;
				end
				S_DIVW: begin
					if (msum_q == '0) begin
						w_q     <= 17'd32768;
						state_q <= S_MX;
					end else if (div_done) begin
						issued_q <= 1'b0;
						w_q      <= div_quot[16:0];
						state_q  <= S_MX;
					end
				end
				S_MX: if (v_s3) begin
					issued_q <= 1'b0;
					mx_q     <= mres_s3[33:0];
					state_q  <= S_MY;
				end
				S_MY: if (v_s3) begin
					issued_q <= 1'b0;
					my_q     <= mres_s3[33:0];
					state_q  <= S_PAX;
				end
				S_PAX: if (v_s3) begin
					issued_q      <= 1'b0;
					cur_i_q.pos_x <= sat32(64'(cur_i_q.pos_x) + mres_s3);
					state_q       <= S_PAY;
				end
				S_PAY: if (v_s3) begin
					issued_q      <= 1'b0;
					cur_i_q.pos_y <= sat32(64'(cur_i_q.pos_y) + mres_s3);
					state_q       <= S_PBX;
				end
				S_PBX: if (v_s3) begin
					issued_q      <= 1'b0;
					cur_j_q.pos_x <= sat32(64'(cur_j_q.pos_x) - mres_s3);
					state_q       <= S_PBY;
				end
				S_PBY: if (v_s3) begin
					issued_q      <= 1'b0;
					cur_j_q.pos_y <= sat32(64'(cur_j_q.pos_y) - mres_s3);
					state_q       <= S_VREL;
				end
				S_VREL: begin
					vx_q    <= {cur_i_q.vel_x[31], cur_i_q.vel_x}
						- {cur_j_q.vel_x[31], cur_j_q.vel_x};
					vy_q    <= {cur_i_q.vel_y[31], cur_i_q.vel_y}
						- {cur_j_q.vel_y[31], cur_j_q.vel_y};
					state_q <= S_VNX;
				end
				S_VNX: if (v_s3) begin
					issued_q <= 1'b0;
					vn_q     <= mres_s3[34:0];
					state_q  <= S_VNY;
				end
				S_VNY: if (v_s3) begin
					issued_q <= 1'b0;
					vn_q     <= vn_q + mres_s3[34:0];
					state_q  <= S_JIMP;
				end
				S_JIMP: begin
					if (!vn_q[34]) begin
						state_q <= S_WRA;
					end else begin
						jimp_q  <= (nv2 > 37'sh3_ffff_ffff) ? 34'h3_ffff_ffff : nv2[33:0];
						state_q <= S_J1;
					end
				end
				S_J1: if (v_s3) begin
					issued_q <= 1'b0;
					j1_q     <= mres_s3[33:0];
					state_q  <= S_J2;
				end
				S_J2: if (v_s3) begin
					issued_q <= 1'b0;
					j2_q     <= mres_s3[33:0];
					state_q  <= S_VAX;
				end
				S_VAX: if (v_s3) begin
					issued_q      <= 1'b0;
					cur_i_q.vel_x <= sat32(64'(cur_i_q.vel_x) + mres_s3);
					state_q       <= S_VAY;
				end
				S_VAY: if (v_s3) begin
					issued_q      <= 1'b0;
					cur_i_q.vel_y <= sat32(64'(cur_i_q.vel_y) + mres_s3);
					state_q       <= S_VBX;
				end
				S_VBX: if (v_s3) begin
					issued_q      <= 1'b0;
					cur_j_q.vel_x <= sat32(64'(cur_j_q.vel_x) - mres_s3);
					state_q       <= S_VBY;
				end
				S_VBY: if (v_s3) begin
					issued_q      <= 1'b0;
					cur_j_q.vel_y <= sat32(64'(cur_j_q.vel_y) - mres_s3);
					state_q       <= S_WRA;
				end
				S_WRA: state_q <= S_WRB;
				S_WRB: state_q <= S_NEXT;
				// advance to the next pair, pass or the output sweep
				S_NEXT: begin
					if (({1'b0, j_q} + CW'(1)) < n_q) begin
						j_q     <= j_q + AW'(1);
						state_q <= S_READ;
					end else if (({1'b0, i_q} + CW'(2)) < n_q) begin
						i_q     <= i_q + AW'(1);
						j_q     <= AW'({1'b0, i_q} + CW'(2));
						state_q <= S_READ;
					end else if (({1'b0, it_q} + 9'd1) < {1'b0, iter_q}) begin
						it_q    <= it_q + 8'd1;
						i_q     <= '0;
						j_q     <= AW'(1);
						state_q <= S_READ;
					end else begin
						k_q     <= '0;
						state_q <= F_READ;
					end
				end
				F_READ: state_q <= F_LOAD;
				F_LOAD: begin
					cur_i_q <= rd_a_q;
					state_q <= F_VX;
				end
				F_VX: if (v_s3) begin
					issued_q      <= 1'b0;
					cur_i_q.vel_x <= sat32(mres_s3);
					state_q       <= F_VY;
				end
				F_VY: if (v_s3) begin
					issued_q      <= 1'b0;
					cur_i_q.vel_y <= sat32(mres_s3);
					state_q       <= F_POS;
				end
				F_POS: begin
					cur_i_q.pos_x <= sat32(64'(cur_i_q.pos_x) + 64'(cur_i_q.vel_x));
					cur_i_q.pos_y <= sat32(64'(cur_i_q.pos_y) + 64'(cur_i_q.vel_y));
					state_q       <= F_EMIT;
				end
				// hold until the output register is free
				F_EMIT: begin
					if (out_free) begin
						res_valid_q        <= 1'b1;
						res_q.new_pos_x    <= cur_i_q.pos_x;
						res_q.new_pos_y    <= cur_i_q.pos_y;
						res_q.new_vel_x    <= cur_i_q.vel_x;
						res_q.new_vel_y    <= cur_i_q.vel_y;
						res_q.final_circle <= (({1'b0, k_q} + CW'(1)) == n_q);
						if (({1'b0, k_q} + CW'(1)) == n_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= F_READ;
						end
					end else if (res_valid_q && !result_stall) begin
						res_valid_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ tb/sv/ccps_checker.sv @@
// ----------------------------------------------------------------------------
// ccps_checker
// Watches the circle, result and configuration channels of the collision
// step, predicts every frame's updated circles in fixed point and compares
// each result transfer, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module ccps_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              circle_valid,
	input  logic              circle_stall,
	input  ccps_pkg::circle_t circle,
	input  logic              result_valid,
	input  logic              result_stall,
	input  ccps_pkg::result_t result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [16:0]       cfg_data,
	output int                failures,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import ccps_pkg::*;

	localparam longint ONE_Q30 = 64'sd1 << 30;

	// predicted frame store
	longint          ent_px [MAX_OBJECTS];
	longint          ent_py [MAX_OBJECTS];
	longint          ent_vx [MAX_OBJECTS];
	longint          ent_vy [MAX_OBJECTS];
	longint unsigned ent_mass [MAX_OBJECTS];
	longint unsigned ent_rad [MAX_OBJECTS];
	int unsigned     loaded;
	logic [7:0]      passes;
	logic [16:0]     damping;

	result_t frame_out_q[$];

	assign pending = frame_out_q.size();

	function automatic longint unsigned magn(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	// (a*b)>>sh, truncated toward zero
	function automatic longint prod_shift(longint a, longint b, int sh);
		logic [127:0] p;
		bit neg;
		neg = (a < 0) != (b < 0);
		p = {64'd0, magn(a)} * {64'd0, magn(b)};
		p = p >> sh;
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// one normal component in Q2.30, clamped to unity
	function automatic longint normal_comp(longint delta, longint unsigned d);
		logic [127:0] q;
		q = ({64'd0, magn(delta)} << 30) / {64'd0, d};
		if (q > 128'(ONE_Q30)) q = 128'(ONE_Q30);
		return delta < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	// push one pair apart and apply the elastic impulse
	function automatic void resolve(int i, int j);
		longint dx, dy, ovl, nx, ny, mx, my, w, wc, vx, vy, vn, jimp, j1, j2;
		longint unsigned rsum, hx, hy, hs, h, d, msum;
		dx = ent_px[i] - ent_px[j];
		dy = ent_py[i] - ent_py[j];
		rsum = ent_rad[i] + ent_rad[j];
		hx = magn(dx) >> 1;
		hy = magn(dy) >> 1;
		hs = rsum >> 1;
		h = hx * hx + hy * hy;
		if (h > hs * hs) return;
		if (dx == 0 && dy == 0) return;
		d = 2 * int_sqrt(h);
		if (d == 0) return;
		ovl = longint'(rsum) - longint'(d);
		if (ovl < 0) ovl = 0;
		nx = normal_comp(dx, d);
		ny = normal_comp(dy, d);
		mx = prod_shift(nx, ovl, 30);
		my = prod_shift(ny, ovl, 30);
		msum = ent_mass[i] + ent_mass[j];
		w = msum != 0 ? longint'((ent_mass[j] << 16) / msum) : 32768;
		wc = 65536 - w;
		ent_px[i] = clamp32(ent_px[i] + prod_shift(mx, w, 16));
		ent_py[i] = clamp32(ent_py[i] + prod_shift(my, w, 16));
		ent_px[j] = clamp32(ent_px[j] - prod_shift(mx, wc, 16));
		ent_py[j] = clamp32(ent_py[j] - prod_shift(my, wc, 16));
		vx = ent_vx[i] - ent_vx[j];
		vy = ent_vy[i] - ent_vy[j];
		vn = prod_shift(vx, nx, 30) + prod_shift(vy, ny, 30);
		if (vn >= 0) return;
		jimp = -2 * vn;
		if (jimp > (64'sd1 << 34) - 1) jimp = (64'sd1 << 34) - 1;
		j1 = prod_shift(jimp, w, 16);
		j2 = prod_shift(jimp, wc, 16);
		ent_vx[i] = clamp32(ent_vx[i] + prod_shift(nx, j1, 30));
		ent_vy[i] = clamp32(ent_vy[i] + prod_shift(ny, j1, 30));
		ent_vx[j] = clamp32(ent_vx[j] - prod_shift(nx, j2, 30));
		ent_vy[j] = clamp32(ent_vy[j] - prod_shift(ny, j2, 30));
	endfunction

	// store one circle; on frame end, run the passes and queue the outputs
	function automatic void load_circle(circle_t c);
		int unsigned n;
		result_t r;
		n = loaded;
		if (n >= MAX_OBJECTS) n = 0;
		ent_px[n] = longint'(c.pos_x);
		ent_py[n] = longint'(c.pos_y);
		ent_vx[n] = longint'(c.vel_x);
		ent_vy[n] = longint'(c.vel_y);
		ent_mass[n] = {32'd0, c.mass};
		ent_rad[n] = {33'd0, c.radius};
		n++;
		loaded = n;
		if (!c.last && n < MAX_OBJECTS) return;
		for (int it = 0; it < passes; it++)
			for (int i = 0; i < n; i++)
				for (int j = i + 1; j < n; j++)
					resolve(i, j);
		for (int i = 0; i < n; i++) begin
			ent_vx[i] = clamp32(prod_shift(ent_vx[i], {47'd0, damping}, 16));
			ent_vy[i] = clamp32(prod_shift(ent_vy[i], {47'd0, damping}, 16));
			ent_px[i] = clamp32(ent_px[i] + ent_vx[i]);
			ent_py[i] = clamp32(ent_py[i] + ent_vy[i]);
			r.new_pos_x = ent_px[i][31:0];
			r.new_pos_y = ent_py[i][31:0];
			r.new_vel_x = ent_vx[i][31:0];
			r.new_vel_y = ent_vy[i][31:0];
			r.final_circle = (i + 1 == n);
			frame_out_q = {frame_out_q, r};
		end
		loaded = 0;
	endfunction

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			loaded = 0;
			passes = ITERATIONS_RESET;
			damping = FRICTION_RESET;
			frame_out_q.delete();
			failures = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (frame_out_q.size() == 0) begin
					$display("%0t: unexpected result transfer %h", $time, result);
					failures++;
				end else begin
					e = frame_out_q.pop_front();
					if (e.new_pos_x !== result.new_pos_x) begin
						$display("%0t: new_pos_x expected %0d actual %0d", $time,
							e.new_pos_x, result.new_pos_x);
						failures++;
					end
					if (e.new_pos_y !== result.new_pos_y) begin
						$display("%0t: new_pos_y expected %0d actual %0d", $time,
							e.new_pos_y, result.new_pos_y);
						failures++;
					end
					if (e.new_vel_x !== result.new_vel_x) begin
						$display("%0t: new_vel_x expected %0d actual %0d", $time,
							e.new_vel_x, result.new_vel_x);
						failures++;
					end
					if (e.new_vel_y !== result.new_vel_y) begin
						$display("%0t: new_vel_y expected %0d actual %0d", $time,
							e.new_vel_y, result.new_vel_y);
						failures++;
					end
					if (e.final_circle !== result.final_circle) begin
						$display("%0t: final_circle expected %0d actual %0d", $time,
							e.final_circle, result.final_circle);
						failures++;
					end
				end
			end
			if (circle_valid && !circle_stall) load_circle(circle);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ITERATIONS) passes = cfg_data[7:0];
				else if (cfg_index == CFG_FRICTION) damping = cfg_data;
			end
		end
	end

endmodule

@@ tb/sv/circle_collision_physics_step_tb.sv @@
// ----------------------------------------------------------------------------
// circle_collision_physics_step_tb
// Drives directed and random frames of circles, register writes and random
// flow control into the collision step; the checker predicts and compares.
// ----------------------------------------------------------------------------
module circle_collision_physics_step_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ccps_pkg::*;

	localparam int CYCLE_LIMIT = 20000000;
	localparam int RANDOM_ITEMS = 70;

	logic        clk;
	logic        arst_n;
	logic        circle_valid;
	logic        circle_stall;
	circle_t     circle;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [16:0] cfg_data;
	int          failures;
	int          pending;
	int          cycles;
	int          sent;
	bit          hold_go;
	bit          hold_taken;
	int          hold_cnt;
	int          burst_cnt;

	circle_collision_physics_step dut (
		.clk, .arst_n, .circle_valid, .circle_stall, .circle,
		.result_valid, .result_stall, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	ccps_checker chk (
		.clk, .arst_n, .circle_valid, .circle_stall, .circle,
		.result_valid, .result_stall, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.failures, .pending
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// end the run at the cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("circle_collision_physics_step_tb NOT OK");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(20, 100);
	endfunction

	// receiver flow control, with one long hold-off on request
	always @(negedge clk or negedge arst_n) begin
		int r;
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_cnt = 0;
			hold_taken = 0;
			burst_cnt = 0;
		end else if (hold_go && !hold_taken) begin
			hold_taken = 1;
			hold_cnt = 3000;
			result_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			result_stall <= 1'b1;
		end else if (burst_cnt > 0) begin
			burst_cnt--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				result_stall <= 1'b0;
				burst_cnt = $urandom_range(1, 20);
			end else if (r < 93) begin
				result_stall <= 1'b1;
				burst_cnt = $urandom_range(0, 2);
			end else begin
				result_stall <= 1'b1;
				burst_cnt = $urandom_range(20, 150);
			end
		end
	end

	function automatic circle_t mk(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
		logic [31:0] vy, logic [31:0] m, logic [30:0] r, logic lst);
		circle_t c;
		c.pos_x = px;
		c.pos_y = py;
		c.vel_x = vx;
		c.vel_y = vy;
		c.mass = m;
		c.radius = r;
		c.last = lst;
		return c;
	endfunction

	// offer one circle, keep valid high across back-to-back transfers
	task automatic send(circle_t c, int gap);
		if (gap > 0) begin
			circle_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		circle <= c;
		circle_valid <= 1'b1;
		do @(posedge clk); while (circle_stall);
		@(negedge clk);
		sent++;
	endtask

	// drop valid and wait until the block has drained
	task automatic wait_idle();
		circle_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// clustered frame so pairs touch, with random content
	task automatic cluster_frame(int n);
		logic [31:0] vx, vy, m;
		for (int k = 0; k < n; k++) begin
			vx = $urandom_range(0, 9) == 0 ? $urandom() : 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
			vy = $urandom_range(0, 9) == 0 ? $urandom() : 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
			m = $urandom_range(0, 9) == 0 ? $urandom() | 32'd1 : $urandom_range(1, 1 << 20);
			send(mk(32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)),
				32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)),
				vx, vy, m, 31'($urandom_range(1 << 16, 1 << 21)), k == n - 1), pick_gap());
		end
	endtask

	initial begin
		int r;
		arst_n = 1'b0;
		circle_valid = 1'b0;
		circle = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ITERATIONS;
		cfg_data = '0;
		cycles = 0;
		sent = 0;
		hold_go = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// default registers: lone circle at the extremes, overlapping approach
		send(mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'hffff_ffff, 31'h7fff_ffff, 1'b1), 0);
		send(mk(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 31'h0002_0000, 1'b0), 0);
		send(mk(32'h0003_0000, 0, 32'hffff_0000, 0, 32'h0002_0000, 31'h0002_0000, 1'b1), 0);
		// coincident centres, then centres too close for a distance
		send(mk(32'h0010_0000, 32'h0010_0000, 0, 0, 1, 31'h0001_0000, 1'b0), 1);
		send(mk(32'h0010_0000, 32'h0010_0000, 0, 0, 1, 31'h0001_0000, 1'b1), 0);
		send(mk(5, 7, 1, 1, 1, 31'h0001_0000, 1'b0), 0);
		send(mk(6, 7, 2, 1, 1, 31'h0001_0000, 1'b1), 0);
		// separating pair
		send(mk(0, 0, 32'hfff0_0000, 0, 32'h0001_0000, 31'h0004_0000, 1'b0), 0);
		send(mk(32'h0002_0000, 0, 32'h0010_0000, 0, 32'h0001_0000, 31'h0004_0000, 1'b1), 0);
		// huge radii and far-apart extremes
		send(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'hffff_ffff, 31'h7fff_ffff, 1'b0), 0);
		send(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			1, 31'h7fff_ffff, 1'b1), 0);
		wait_idle();

		// no collision passes, friction above one
		write_reg(CFG_ITERATIONS, 17'd0);
		write_reg(CFG_FRICTION, 17'h1ffff);
		send(mk(0, 0, 32'h7fff_ffff, 32'h8000_0000, 1, 31'h0001_0000, 1'b0), 0);
		send(mk(32'h0000_8000, 0, 32'h4000_0000, 32'hc000_0000, 1, 31'h0001_0000, 1'b1), 0);
		wait_idle();

		// most passes, friction zero
		write_reg(CFG_ITERATIONS, 17'd255);
		write_reg(CFG_FRICTION, 17'd0);
		send(mk(0, 0, 32'h0004_0000, 0, 32'h0003_0000, 31'h0003_0000, 1'b0), 0);
		send(mk(32'h0004_0000, 32'h0001_0000, 32'hfffc_0000, 0, 32'h0001_0000,
			31'h0003_0000, 1'b1), 0);
		wait_idle();

		// full store with no last mark, circles far apart
		write_reg(CFG_ITERATIONS, 17'd1);
		write_reg(CFG_FRICTION, 17'd65536);
		for (int k = 0; k < MAX_OBJECTS; k++)
			send(mk(k << 22, 32'(-(k << 21)), $urandom(), $urandom(), $urandom() | 32'd1,
				31'd0, 1'b0), pick_gap());
		wait_idle();

		// random frames; the long receiver hold lands in the middle
		while (sent < 80 + RANDOM_ITEMS) begin
			if (sent > 110 && !hold_go) hold_go = 1;
			r = $urandom_range(0, 99);
			if (r < 10) begin
				// sender pauses for drain, then changes the settings
				wait_idle();
				write_reg(CFG_ITERATIONS, 17'($urandom_range(1, 3)));
				write_reg(CFG_FRICTION, $urandom_range(0, 9) == 0 ? 17'($urandom_range(0, 65536))
					: 17'($urandom_range(60000, 65536)));
			end else if (r < 80) begin
				cluster_frame($urandom_range(1, 5));
			end else begin
				// noise with every field at full range
				send(mk($urandom(), $urandom(), $urandom(), $urandom(), $urandom() | 32'd1,
					31'($urandom()), $urandom_range(0, 3) == 0), pick_gap());
			end
		end
		// close any open frame
		send(mk($urandom(), $urandom(), $urandom(), $urandom(), $urandom() | 32'd1,
			31'($urandom()), 1'b1), 0);
		wait_idle();
		repeat (500) @(negedge clk);

		if (failures == 0 && pending == 0) begin
			$display("circle_collision_physics_step_tb OK");
		end else begin
			$display("circle_collision_physics_step_tb NOT OK");
		end
		$finish;
	end

endmodule
